/* rtl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the sequential list table
// Sizes, action codes, sequencer states and the memory request bundle.
// ----------------------------------------------------------------------------
package slt_pkg;

	// list size and field widths
	localparam int CAPACITY = 32;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 6;
	localparam int ACT_W    = 3;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);
	// compare width that holds a count, a position and one more
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR  = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_DELETE = 3'd2,
		ACT_LOCATE = 3'd3,
		ACT_GET    = 3'd4
	} action_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// one write port and one read port per cycle
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

/* rtl/slt_ram.sv */
// ----------------------------------------------------------------------------
// slt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module slt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/slt_seq.sv */
// ----------------------------------------------------------------------------
// slt_seq: list sequencer
// Decodes one action, walks the element memory one entry a cycle (shift up,
// shift down, search or single read) and returns one result beat.
// ----------------------------------------------------------------------------
module slt_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [slt_pkg::ACT_W-1:0]           action,
	input  logic [slt_pkg::POS_W-1:0]           position,
	input  logic signed [slt_pkg::DATA_W-1:0]   value,
	output logic                                busy,
	output logic                                done,
	output logic                                ok,
	output logic signed [slt_pkg::DATA_W-1:0]   value_out,
	output logic [slt_pkg::POS_W-1:0]           found_position,
	output logic [slt_pkg::POS_W-1:0]           list_length,
	output logic                                is_empty,
	output slt_pkg::mem_req_t                   mem_req,
	input  logic [slt_pkg::DATA_W-1:0]          rdata
);

	slt_pkg::state_t                  state_q, state_d;
	slt_pkg::action_t                 op_q, op_d;
	logic [slt_pkg::CNT_W-1:0]        cnt_q, cnt_d;
	logic [slt_pkg::CNT_W-1:0]        ptr_q, ptr_d;
	logic [slt_pkg::CNT_W-1:0]        rem_q, rem_d;
	logic [slt_pkg::ADDR_W-1:0]       tgt_q, tgt_d;
	logic signed [slt_pkg::DATA_W-1:0] val_q, val_d;
	logic                             ok_q, ok_d;
	logic signed [slt_pkg::DATA_W-1:0] vout_q, vout_d;
	logic [slt_pkg::POS_W-1:0]        found_q, found_d;
	logic                             done_q, done_d;
	logic                             rd_vld_s1;
	logic [slt_pkg::ADDR_W-1:0]       rd_addr_s1;
	logic                             issue;
	logic                             hit;
	logic                             last;
	logic [slt_pkg::CMP_W-1:0]        pos_x, cnt_x;
	logic                             rd_pos_ok, ins_pos_ok;

	// position checks against the current length
	assign pos_x      = slt_pkg::CMP_W'(position);
	assign cnt_x      = slt_pkg::CMP_W'(cnt_q);
	assign rd_pos_ok  = (position != '0) && (pos_x <= cnt_x);
	assign ins_pos_ok = (position != '0) && (pos_x <= cnt_x + 1'b1) &&
	                    (cnt_x < slt_pkg::CMP_W'(slt_pkg::CAPACITY));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= slt_pkg::ST_IDLE;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			done_q    <= done_d;
			rd_vld_s1 <= issue;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		op_q       <= op_d;
		ptr_q      <= ptr_d;
		rem_q      <= rem_d;
		tgt_q      <= tgt_d;
		val_q      <= val_d;
		ok_q       <= ok_d;
		vout_q     <= vout_d;
		found_q    <= found_d;
		rd_addr_s1 <= ptr_q[slt_pkg::ADDR_W-1:0];
	end

	// next state, memory requests and result
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cnt_d   = cnt_q;
		ptr_d   = ptr_q;
		rem_d   = rem_q;
		tgt_d   = tgt_q;
		val_d   = val_q;
		ok_d    = ok_q;
		vout_d  = vout_q;
		found_d = found_q;
		done_d  = 1'b0;
		issue   = 1'b0;
		hit     = 1'b0;
		last    = 1'b0;
		mem_req = '0;
		mem_req.raddr = ptr_q[slt_pkg::ADDR_W-1:0];

		unique case (state_q)
			slt_pkg::ST_IDLE: begin
				if (start) begin
					op_d    = slt_pkg::action_t'(action);
					val_d   = value;
					tgt_d   = slt_pkg::ADDR_W'(pos_x - 1'b1);
					ok_d    = 1'b0;
					vout_d  = '0;
					found_d = '0;
					unique case (slt_pkg::action_t'(action))
						slt_pkg::ACT_CLEAR: begin
							cnt_d  = '0;
							ok_d   = 1'b1;
							done_d = 1'b1;
						end
						slt_pkg::ACT_INSERT: begin
							// walk from the last entry down to the slot
							if (ins_pos_ok) begin
								rem_d   = slt_pkg::CNT_W'(cnt_x - pos_x + 1'b1);
								ptr_d   = cnt_q - 1'b1;
								state_d = slt_pkg::ST_RUN;
							end else begin
								done_d = 1'b1;
							end
						end
						slt_pkg::ACT_DELETE: begin
							// read the victim, then walk up to the end
							if (rd_pos_ok) begin
								rem_d   = slt_pkg::CNT_W'(cnt_x - pos_x + 1'b1);
								ptr_d   = slt_pkg::CNT_W'(pos_x - 1'b1);
								state_d = slt_pkg::ST_RUN;
							end else begin
								done_d = 1'b1;
							end
						end
						slt_pkg::ACT_LOCATE: begin
							ok_d = 1'b1;
							if (cnt_q == '0) begin
								done_d = 1'b1;
							end else begin
								rem_d   = cnt_q;
								ptr_d   = '0;
								state_d = slt_pkg::ST_RUN;
							end
						end
						slt_pkg::ACT_GET: begin
							if (rd_pos_ok) begin
								rem_d   = slt_pkg::CNT_W'(1);
								ptr_d   = slt_pkg::CNT_W'(pos_x - 1'b1);
								state_d = slt_pkg::ST_RUN;
							end else begin
								done_d = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end

			slt_pkg::ST_RUN: begin
				// read data of the previous cycle
				if (rd_vld_s1) begin
					unique case (op_q)
						slt_pkg::ACT_INSERT: begin
							mem_req.we    = 1'b1;
							mem_req.waddr = rd_addr_s1 + 1'b1;
							mem_req.wdata = rdata;
						end
						slt_pkg::ACT_DELETE: begin
							if (rd_addr_s1 == tgt_q) begin
								vout_d = rdata;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = rd_addr_s1 - 1'b1;
								mem_req.wdata = rdata;
							end
						end
						slt_pkg::ACT_LOCATE: begin
							if (rdata == val_q) begin
								hit     = 1'b1;
								found_d = slt_pkg::POS_W'(slt_pkg::CNT_W'(rd_addr_s1) + 1'b1);
							end
						end
						slt_pkg::ACT_GET: begin
							vout_d = rdata;
						end
						default: begin
						end
					endcase
				end

				last = (rem_q == '0) && !rd_vld_s1;

				if (hit || last) begin
					// wrap up: back to idle; insert writes the new value, insert and delete update the length
					state_d = slt_pkg::ST_IDLE;
					done_d  = 1'b1;
					ok_d    = 1'b1;
					unique case (op_q)
						slt_pkg::ACT_INSERT: begin
							mem_req.we    = 1'b1;
							mem_req.waddr = tgt_q;
							mem_req.wdata = val_q;
							cnt_d         = cnt_q + 1'b1;
						end
						slt_pkg::ACT_DELETE: begin
							cnt_d = cnt_q - 1'b1;
						end
						default: begin
						end
					endcase
				end else if (rem_q != '0) begin
					issue = 1'b1;
					rem_d = rem_q - 1'b1;
					ptr_d = (op_q == slt_pkg::ACT_INSERT) ? ptr_q - 1'b1 : ptr_q + 1'b1;
				end
			end

			default: begin
				state_d = slt_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy           = (state_q == slt_pkg::ST_RUN);
	assign done           = done_q;
	assign ok             = ok_q;
	assign value_out      = vout_q;
	assign found_position = found_q;
	assign list_length    = slt_pkg::POS_W'(cnt_q);
	assign is_empty       = (cnt_q == '0);

	// a shift write never lands on the entry being read
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && issue) |-> (mem_req.waddr != mem_req.raddr))
		else $error("write and read hit the same entry");

	// length stays within the store
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= slt_pkg::CMP_W'(slt_pkg::CAPACITY))
		else $error("length beyond capacity");

	// read data only returns while a walk is running
	a_rd_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == slt_pkg::ST_RUN))
		else $error("read return outside a walk");

	// an accepted action either answers at once or starts a walk
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted action lost");

endmodule

/* rtl/sequential_list_table.sv */
// ----------------------------------------------------------------------------
// sequential_list_table: ordered list of signed 32-bit words
// Usage: drive action, position and value with start; the beat is taken at a
// rising edge where start is high and busy is low. Actions are clear, insert
// at a 1-based position, delete at a position, locate by value and get by
// position. Exactly one result beat follows each accepted beat: done is high
// for one cycle with ok, value_out, found_position, list_length and is_empty.
// The receiver cannot stall; the result is valid only in the done cycle.
// Clear, refused and unknown actions and locate on an empty list answer
// without a walk. Get reads one entry; delete walks from the position to
// the end, insert from the end down to the position, and an append at
// length + 1 walks no entry. Locate walks until the first match, or to the
// end when the value is absent. The walks are paced by the element memory,
// which moves one entry per cycle through its single read port with
// registered read data.
// One beat is worked at a time; busy is high during a walk, and the next beat
// can be taken in the done cycle of the previous one.
// Reset (arst_n low) empties the list; the store itself is not cleared and
// needs no clearing pass, since only entries below the length are read.
// ----------------------------------------------------------------------------
module sequential_list_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [slt_pkg::ACT_W-1:0]          action,
	input  logic [slt_pkg::POS_W-1:0]          position,
	input  logic signed [slt_pkg::DATA_W-1:0]  value,
	output logic                               done,
	output logic                               ok,
	output logic signed [slt_pkg::DATA_W-1:0]  value_out,
	output logic [slt_pkg::POS_W-1:0]          found_position,
	output logic [slt_pkg::POS_W-1:0]          list_length,
	output logic                               is_empty
);

	slt_pkg::mem_req_t           mem_req;
	logic [slt_pkg::DATA_W-1:0]  rdata;

	// action sequencer
	slt_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.action         (action),
		.position       (position),
		.value          (value),
		.busy           (busy),
		.done           (done),
		.ok             (ok),
		.value_out      (value_out),
		.found_position (found_position),
		.list_length    (list_length),
		.is_empty       (is_empty),
		.mem_req        (mem_req),
		.rdata          (rdata)
	);

	// element store
	slt_ram #(
		.WIDTH (slt_pkg::DATA_W),
		.DEPTH (slt_pkg::CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

endmodule
